@@ src/mmt_pkg.sv @@
// shared types, constants and helpers for the two-way mac match table
package mmt_pkg;

   // table geometry
   localparam int BUCKETS  = 1024;
   localparam int ROW_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

   // field widths
   localparam int MODE_W   = 2;
   localparam int BUCKET_W = 10;
   localparam int MAC_W    = 48;
   localparam int RES_W    = 16;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_ZERO = 2'd2;

   // one slot: mac key and result, result zero marks it empty
   typedef struct packed {
      logic [MAC_W-1:0] mac;
      logic [RES_W-1:0] res;
   } slot_type;

   // one bucket row holds both ways
   typedef struct packed {
      slot_type way1;
      slot_type way0;
   } row_type;

   // controller to datapath commands
   typedef struct packed {
      logic                load;
      logic                commit;
      logic                clear;
      logic [ROW_BITS-1:0] clr_row;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic rsp_busy;
   } stat_type;

   // bucket index modulo BUCKETS by conditional subtraction of shifted copies
   function automatic logic [ROW_BITS-1:0] bucket_wrap(input logic [BUCKET_W-1:0] b);
      logic [31:0] r;
      r = 32'(b);
      for (int k = BUCKET_W - 1; k >= 0; k--) begin
         if (r >= (32'(BUCKETS) << k)) begin
            r = r - (32'(BUCKETS) << k);
         end
      end
      return r[ROW_BITS-1:0];
   endfunction

endpackage

@@ src/mmt_ctrl.sv @@
// controller: reset clearing sweep, item accept and commit sequencing
module mmt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mmt_pkg::stat_type stat,
   output mmt_pkg::cmd_type  cmd
);
   import mmt_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0]          state_ff;
   logic [1:0]          state_in;
   logic [ROW_BITS-1:0] clr_row_ff;
   logic [ROW_BITS-1:0] clr_row_in;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      clr_row_in  = clr_row_ff;
      cmd         = '0;
      cmd.clr_row = clr_row_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (clr_row_ff == ROW_BITS'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_row_in = clr_row_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_row_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_row_ff <= clr_row_in;
      end
   end

endmodule

@@ src/mmt_datapath.sv @@
// datapath: bucket memory, way match, update and result register
module mmt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  mmt_pkg::cmd_type                cmd,
   output mmt_pkg::stat_type               stat,
   input  logic [mmt_pkg::MODE_W-1:0]      req_mode,
   input  logic [mmt_pkg::BUCKET_W-1:0]    req_bucket,
   input  logic [mmt_pkg::MAC_W-1:0]       req_mac_addr,
   input  logic [mmt_pkg::RES_W-1:0]       req_result_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mmt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [mmt_pkg::RES_W-1:0]       rsp_found_value
);
   import mmt_pkg::*;

   row_type mem [BUCKETS];

   logic [MODE_W-1:0]   mode_ff;
   logic [ROW_BITS-1:0] row_ff;
   logic [MAC_W-1:0]    mac_ff;
   logic [RES_W-1:0]    res_ff;
   row_type             rd_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [RES_W-1:0]    found_ff;

   logic                hit0;
   logic                hit1;
   logic                empty0;
   logic                empty1;
   logic                wr_en;
   row_type             wr_row;
   logic [STATUS_W-1:0] status_in;
   logic [RES_W-1:0]    found_in;
   slot_type            new_slot;

   // way match on the row read for the current item
   assign empty0   = (rd_ff.way0.res == '0);
   assign empty1   = (rd_ff.way1.res == '0);
   assign hit0     = !empty0 && (rd_ff.way0.mac == mac_ff);
   assign hit1     = !empty1 && (rd_ff.way1.mac == mac_ff);
   assign new_slot = '{mac: mac_ff, res: res_ff};

   // operation decode and row update
   always_comb begin
      wr_en     = 1'b0;
      wr_row    = rd_ff;
      status_in = STAT_MISS;
      found_in  = '0;
      unique case (mode_ff)
         MODE_ADD: begin
            priority if (res_ff == '0) begin
               status_in = STAT_ZERO;
            end else if (hit0) begin
               wr_en       = 1'b1;
               wr_row.way0 = new_slot;
               status_in   = STAT_OK;
            end else if (hit1) begin
               wr_en       = 1'b1;
               wr_row.way1 = new_slot;
               status_in   = STAT_OK;
            end else if (empty0) begin
               wr_en       = 1'b1;
               wr_row.way0 = new_slot;
               status_in   = STAT_OK;
            end else if (empty1) begin
               wr_en       = 1'b1;
               wr_row.way1 = new_slot;
               status_in   = STAT_OK;
            end else begin
               status_in = STAT_MISS;
            end
         end
         MODE_LOOKUP: begin
            priority if (hit0) begin
               found_in  = rd_ff.way0.res;
               status_in = STAT_OK;
            end else if (hit1) begin
               found_in  = rd_ff.way1.res;
               status_in = STAT_OK;
            end else begin
               status_in = STAT_MISS;
            end
         end
         MODE_REMOVE: begin
            priority if (hit0) begin
               wr_en       = 1'b1;
               wr_row.way0 = '0;
               status_in   = STAT_OK;
            end else if (hit1) begin
               wr_en       = 1'b1;
               wr_row.way1 = '0;
               status_in   = STAT_OK;
            end else begin
               status_in = STAT_MISS;
            end
         end
         default: begin
            status_in = STAT_MISS;
         end
      endcase
   end

   // item capture and bucket read
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         row_ff  <= bucket_wrap(req_bucket);
         mac_ff  <= req_mac_addr;
         res_ff  <= req_result_value;
         rd_ff   <= mem[bucket_wrap(req_bucket)];
      end
   end

   // bucket write: clearing sweep or item update
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[cmd.clr_row] <= '0;
      end else if (cmd.commit && wr_en) begin
         mem[row_ff] <= wr_row;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_value = found_ff;

endmodule

@@ src/mac_match_two_way_table_unit.sv @@
// top level of the two-way bucketed mac match table
// Bucketed MAC table with two ways per bucket, one 128-bit memory row per
// bucket. Each item passes an accept step, which reads the bucket row into
// a register, and a match step, which compares both ways, writes the row
// back and loads the result register; that single read-modify-write of the
// bucket memory means a new item is taken only after the current one has
// committed. If the previous result is still held in the result register,
// the item waits in its match step until that result is taken. After reset
// the table is swept clear one bucket per cycle, and req_ready stays low
// until the sweep ends.
module mac_match_two_way_table_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mmt_pkg::MODE_W-1:0]      req_mode,
   input  logic [mmt_pkg::BUCKET_W-1:0]    req_bucket,
   input  logic [mmt_pkg::MAC_W-1:0]       req_mac_addr,
   input  logic [mmt_pkg::RES_W-1:0]       req_result_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mmt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [mmt_pkg::RES_W-1:0]       rsp_found_value
);
   import mmt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   mmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table storage and match logic
   mmt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_bucket       (req_bucket),
      .req_mac_addr     (req_mac_addr),
      .req_result_value (req_result_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_found_value  (rsp_found_value)
   );

endmodule
